>>> rtl/core/gaussian_2d_conic_and_bounds_core_defines.svh
// Assertion macros shared by the conic and bounds core.
`ifndef GAUSSIAN_2D_CONIC_AND_BOUNDS_CORE_DEFINES_SVH
`define GAUSSIAN_2D_CONIC_AND_BOUNDS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define GCB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("core check failed");

// Next-cycle implication, sampled on clk and off during reset.
`define GCB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("core check failed");

`endif

>>> rtl/core/gcb_pkg.sv
// Shared types, constants and helpers of the conic and bounds core.
package gcb_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int CFG_W = 31;
	localparam int IDX_W = 3;
	localparam int DIM_W = 13;
	localparam int CONIC_N = 4;
	localparam int QUO_W = 32;
	localparam int DIV_W = 64;

	localparam logic [CFG_W-1:0] RST_MIN_COV = 31'd66;
	localparam logic [CFG_W-1:0] RST_SIGMA = 31'd196608;
	localparam logic RST_COMPACT = 1'b0;
	localparam logic [CFG_W-1:0] RST_BETA = 31'd196608;
	localparam logic [DIM_W-1:0] RST_WIDTH = 13'd1024;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd1024;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_COV = 3'd0,
		REG_SIGMA = 3'd1,
		REG_COMPACT = 3'd2,
		REG_BETA = 3'd3,
		REG_WIDTH = 3'd4,
		REG_HEIGHT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DIV_W-1:0] dsc;
		logic signed [32:0] tr;
		logic [CONIC_N-1:0] neg;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} div_side_t;

	typedef struct packed {
		logic [CONIC_N-1:0][31:0] conic;
		logic signed [32:0] tr;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} sq1_side_t;

	typedef struct packed {
		logic [CONIC_N-1:0][31:0] conic;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} sq2_side_t;

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [15:0] clamp16(input logic signed [63:0] v);
		logic [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -64'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/gcb_div.sv
// Pipelined restoring divider, four numerators over one shared divisor, one bit per stage.
module gcb_div import gcb_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [DIV_W-1:0] d,
	input logic [CONIC_N-1:0][31:0] mag,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [CONIC_N-1:0][QUO_W-1:0] q,
	output logic [CONIC_N-1:0] ovf,
	output logic [SIDE_W-1:0] side_out
);

	localparam int NW = 32 + 2 * FRAC_BITS;
	localparam int HW = NW - QUO_W;

	logic vld_s [0:QUO_W];
	logic [DIV_W-1:0] d_s [0:QUO_W];
	logic [CONIC_N-1:0][DIV_W-1:0] r_s [0:QUO_W];
	logic [CONIC_N-1:0][QUO_W-1:0] q_s [0:QUO_W];
	logic [CONIC_N-1:0][QUO_W-1:0] lo_s [0:QUO_W];
	logic [CONIC_N-1:0] ovf_s [0:QUO_W];
	logic [SIDE_W-1:0] side_s [0:QUO_W];

	logic [CONIC_N-1:0][DIV_W-1:0] r_init;
	logic [CONIC_N-1:0][QUO_W-1:0] lo_init;
	logic [CONIC_N-1:0] ovf_init;

	// The high part of the shifted numerator must stay below the divisor, or the
	// quotient cannot fit in the quotient width.
	always_comb begin
		logic [NW-1:0] full;
		logic [DIV_W-1:0] hi;
		for (int l = 0; l < CONIC_N; l++) begin
			full = {mag[l], {(2 * FRAC_BITS){1'b0}}};
			hi = {{(DIV_W - HW){1'b0}}, full[NW-1:QUO_W]};
			ovf_init[l] = hi >= d;
			r_init[l] = ovf_init[l] ? '0 : hi;
			lo_init[l] = full[QUO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= d;
			r_s[0] <= r_init;
			q_s[0] <= '0;
			lo_s[0] <= lo_init;
			ovf_s[0] <= ovf_init;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [CONIC_N-1:0][DIV_W-1:0] r_nx;
		logic [CONIC_N-1:0][QUO_W-1:0] q_nx;

		always_comb begin
			logic [DIV_W:0] t;
			logic [DIV_W:0] diff;
			logic ge;
			for (int l = 0; l < CONIC_N; l++) begin
				t = {r_s[k-1][l], lo_s[k-1][l][QUO_W-1]};
				diff = t - {1'b0, d_s[k-1]};
				ge = t >= {1'b0, d_s[k-1]};
				r_nx[l] = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
				q_nx[l] = {q_s[k-1][l][QUO_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k] <= d_s[k-1];
				r_s[k] <= r_nx;
				q_s[k] <= q_nx;
				for (int l = 0; l < CONIC_N; l++) begin
					lo_s[k][l] <= {lo_s[k-1][l][QUO_W-2:0], 1'b0};
				end
				ovf_s[k] <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign q = q_s[QUO_W];
	assign ovf = ovf_s[QUO_W];
	assign side_out = side_s[QUO_W];

endmodule

>>> rtl/core/gcb_isqrt.sv
// Pipelined floor square root, one root bit per stage.
module gcb_isqrt import gcb_pkg::*; #(
	parameter int N_W = DIV_W,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [N_W-1:0] n,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [N_W/2-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int R_W = N_W / 2;

	logic vld_s [0:R_W];
	logic [N_W-1:0] n_s [0:R_W];
	logic [R_W+1:0] rem_s [0:R_W];
	logic [R_W-1:0] res_s [0:R_W];
	logic [SIDE_W-1:0] side_s [0:R_W];

	assign vld_s[0] = in_valid;
	assign n_s[0] = n;
	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 1; k <= R_W; k++) begin : g_step
		logic [R_W+1:0] cur;
		logic [R_W+1:0] trial;
		logic ge;

		// The remainder stays below 2^R_W before each step, so its top bits drop.
		assign cur = {rem_s[k-1][R_W-1:0], n_s[k-1][N_W-1 -: 2]};
		assign trial = {res_s[k-1], 2'b01};
		assign ge = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= {n_s[k-1][N_W-3:0], 2'b00};
				rem_s[k] <= ge ? (cur - trial) : cur;
				res_s[k] <= {res_s[k-1][R_W-2:0], ge};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[R_W];
	assign root = res_s[R_W];
	assign side_out = side_s[R_W];

endmodule

>>> rtl/core/gaussian_2d_conic_and_bounds_core.sv
// Top level of the 2D Gaussian conic and screen bounds core.
// One Gaussian enters per clock and one result leaves per clock when out_stall is low; the
// path runs through the one-bit-per-stage conic divider and the two square root pipelines
// in series. A high out_stall on a waiting result freezes the whole pipeline and raises
// in_stall in the same cycle. The user must write registers through wr_en, wr_index and
// wr_data only while no item is in flight; the block does not enforce this. An index past
// the last register is ignored.
module gaussian_2d_conic_and_bounds_core import gcb_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_index,
	input logic [CFG_W-1:0] wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] mean_x,
	input logic signed [31:0] mean_y,
	input logic signed [31:0] cov_xx,
	input logic signed [31:0] cov_xy,
	input logic signed [31:0] cov_yx,
	input logic signed [31:0] cov_yy,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] conic_xx,
	output logic signed [31:0] conic_xy,
	output logic signed [31:0] conic_yx,
	output logic signed [31:0] conic_yy,
	output logic signed [15:0] box_min_x,
	output logic signed [15:0] box_max_x,
	output logic signed [15:0] box_min_y,
	output logic signed [15:0] box_max_y,
	output logic visible
);

	`include "gaussian_2d_conic_and_bounds_core_defines.svh"

	localparam int LAM_W = 33;
	localparam int LN_W = LAM_W + FRAC_BITS;
	localparam int L_W = LN_W + (LN_W % 2);
	localparam int RT_W = L_W / 2;
	localparam int PR_W = CFG_W + RT_W;
	localparam int RAD_W = PR_W - FRAC_BITS;

	// Configuration registers.
	logic [CFG_W-1:0] min_cov_q, sigma_q, beta_q;
	logic compact_q;
	logic [DIM_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cov_q <= RST_MIN_COV;
			sigma_q <= RST_SIGMA;
			compact_q <= RST_COMPACT;
			beta_q <= RST_BETA;
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MIN_COV: min_cov_q <= wr_data;
				REG_SIGMA: sigma_q <= wr_data;
				REG_COMPACT: compact_q <= wr_data[0];
				REG_BETA: beta_q <= wr_data;
				REG_WIDTH: width_q <= wr_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	assign adv = !(v_s9 && out_stall);
	assign in_stall = !adv;

	// Stage 1: regularized diagonal.
	logic signed [31:0] s00_s1, s11_s1, s01_s1, s10_s1, mx_s1, my_s1;
	logic signed [33:0] sum00, sum11;

	assign sum00 = {{2{cov_xx[31]}}, cov_xx} + {3'b000, min_cov_q};
	assign sum11 = {{2{cov_yy[31]}}, cov_yy} + {3'b000, min_cov_q};

	always_ff @(posedge clk) begin
		if (adv) begin
			s00_s1 <= (sum00[31] && !sum00[33]) ? 32'sh7FFFFFFF : sum00[31:0];
			s11_s1 <= (sum11[31] && !sum11[33]) ? 32'sh7FFFFFFF : sum11[31:0];
			s01_s1 <= cov_xy;
			s10_s1 <= cov_yx;
			mx_s1 <= mean_x;
			my_s1 <= mean_y;
		end
	end

	// Stage 2: products for the determinant, diagonal gap and conic numerators.
	logic signed [63:0] pd0_s2, pd1_s2;
	logic [31:0] ad_s2;
	logic signed [32:0] tr_s2;
	logic [CONIC_N-1:0][31:0] mag_s2;
	logic [CONIC_N-1:0] neg_s2;
	logic signed [31:0] mx_s2, my_s2;
	logic signed [32:0] gap;

	assign gap = {s00_s1[31], s00_s1} - {s11_s1[31], s11_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			pd0_s2 <= s00_s1 * s11_s1;
			pd1_s2 <= s01_s1 * s10_s1;
			ad_s2 <= gap[32] ? 32'(-gap) : gap[31:0];
			tr_s2 <= {s00_s1[31], s00_s1} + {s11_s1[31], s11_s1};
			mag_s2 <= {abs32(s00_s1), abs32(s10_s1), abs32(s01_s1), abs32(s11_s1)};
			neg_s2 <= {s00_s1[31], (s10_s1 > 32'sd0), (s01_s1 > 32'sd0), s11_s1[31]};
			mx_s2 <= mx_s1;
			my_s2 <= my_s1;
		end
	end

	// Stage 3: floored determinant and squared gap.
	logic [DIV_W-1:0] det_s3;
	logic [63:0] dsq_s3;
	logic signed [63:0] pd1_s3;
	logic signed [32:0] tr_s3;
	logic [CONIC_N-1:0][31:0] mag_s3;
	logic [CONIC_N-1:0] neg_s3;
	logic signed [31:0] mx_s3, my_s3;
	logic signed [64:0] det_w, det_floor;

	assign det_w = {pd0_s2[63], pd0_s2} - {pd1_s2[63], pd1_s2};
	// A zero regularizer still keeps the divisor at or above one LSB.
	assign det_floor = (min_cov_q == '0) ? 65'sd1 :
		{{(34 - FRAC_BITS){1'b0}}, min_cov_q, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3 <= (det_w <= det_floor) ? det_floor[DIV_W-1:0] : det_w[DIV_W-1:0];
			dsq_s3 <= ad_s2 * ad_s2;
			pd1_s3 <= pd1_s2;
			tr_s3 <= tr_s2;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			mx_s3 <= mx_s2;
			my_s3 <= my_s2;
		end
	end

	// Stage 4: eigenvalue discriminant, clipped to the unsigned 64-bit range.
	logic [DIV_W-1:0] det_s4;
	logic [63:0] dsc_s4;
	logic signed [32:0] tr_s4;
	logic [CONIC_N-1:0][31:0] mag_s4;
	logic [CONIC_N-1:0] neg_s4;
	logic signed [31:0] mx_s4, my_s4;
	logic signed [65:0] dsc_w;

	assign dsc_w = $signed({2'b00, dsq_s3}) + $signed({pd1_s3, 2'b00});

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= det_s3;
			if (dsc_w[65]) begin
				dsc_s4 <= '0;
			end else if (dsc_w[64]) begin
				dsc_s4 <= '1;
			end else begin
				dsc_s4 <= dsc_w[63:0];
			end
			tr_s4 <= tr_s3;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			mx_s4 <= mx_s3;
			my_s4 <= my_s3;
		end
	end

	// Conic division.
	div_side_t div_in, div_out;
	logic div_valid;
	logic [CONIC_N-1:0][QUO_W-1:0] quo;
	logic [CONIC_N-1:0] quo_ovf;

	assign div_in = '{dsc: dsc_s4, tr: tr_s4, neg: neg_s4, mx: mx_s4, my: my_s4};

	gcb_div #(
		.FRAC_BITS(FRAC_BITS),
		.SIDE_W($bits(div_side_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s4),
		.d(det_s4),
		.mag(mag_s4),
		.side_in(div_in),
		.out_valid(div_valid),
		.q(quo),
		.ovf(quo_ovf),
		.side_out(div_out)
	);

	// Stage 5: signed and saturated conic.
	logic [CONIC_N-1:0][31:0] conic_s5;
	logic [63:0] dsc_s5;
	logic signed [32:0] tr_s5;
	logic signed [31:0] mx_s5, my_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < CONIC_N; l++) begin
				if (div_out.neg[l]) begin
					conic_s5[l] <= (quo_ovf[l] || quo[l][QUO_W-1]) ? 32'h80000000 : -quo[l];
				end else begin
					conic_s5[l] <= (quo_ovf[l] || quo[l] >= 32'h7FFFFFFF) ? 32'h7FFFFFFF :
						quo[l];
				end
			end
			dsc_s5 <= div_out.dsc;
			tr_s5 <= div_out.tr;
			mx_s5 <= div_out.mx;
			my_s5 <= div_out.my;
		end
	end

	// Root of the discriminant.
	sq1_side_t sq1_in, sq1_out;
	logic sq1_valid;
	logic [31:0] root1;

	assign sq1_in = '{conic: conic_s5, tr: tr_s5, mx: mx_s5, my: my_s5};

	gcb_isqrt #(
		.N_W(DIV_W),
		.SIDE_W($bits(sq1_side_t))
	) u_sqrt_dsc (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s5),
		.n(dsc_s5),
		.side_in(sq1_in),
		.out_valid(sq1_valid),
		.root(root1),
		.side_out(sq1_out)
	);

	// Stage 6: largest eigenvalue, floored at the regularizer.
	logic [LAM_W-1:0] lam_s6;
	logic [CONIC_N-1:0][31:0] conic_s6;
	logic signed [31:0] mx_s6, my_s6;
	logic signed [33:0] lam_sum, lam_half;

	assign lam_sum = $signed({sq1_out.tr[32], sq1_out.tr}) + $signed({2'b00, root1});
	assign lam_half = lam_sum >>> 1;

	always_ff @(posedge clk) begin
		if (adv) begin
			lam_s6 <= (lam_half < $signed({3'b000, min_cov_q})) ? {2'b00, min_cov_q} :
				lam_half[LAM_W-1:0];
			conic_s6 <= sq1_out.conic;
			mx_s6 <= sq1_out.mx;
			my_s6 <= sq1_out.my;
		end
	end

	// Root of the eigenvalue.
	sq2_side_t sq2_in, sq2_out;
	logic sq2_valid;
	logic [RT_W-1:0] root2;
	logic [L_W-1:0] lam_wide;

	assign sq2_in = '{conic: conic_s6, mx: mx_s6, my: my_s6};
	assign lam_wide = {{(L_W - LN_W){1'b0}}, lam_s6, {FRAC_BITS{1'b0}}};

	gcb_isqrt #(
		.N_W(L_W),
		.SIDE_W($bits(sq2_side_t))
	) u_sqrt_lam (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s6),
		.n(lam_wide),
		.side_in(sq2_in),
		.out_valid(sq2_valid),
		.root(root2),
		.side_out(sq2_out)
	);

	// Stage 7: radius product.
	logic [CFG_W-1:0] factor;
	logic [PR_W-1:0] prod_s7;
	logic [CONIC_N-1:0][31:0] conic_s7;
	logic signed [31:0] mx_s7, my_s7;

	assign factor = (compact_q && beta_q < sigma_q) ? beta_q : sigma_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s7 <= factor * root2;
			conic_s7 <= sq2_out.conic;
			mx_s7 <= sq2_out.mx;
			my_s7 <= sq2_out.my;
		end
	end

	// Stage 8: exact box bounds.
	logic signed [63:0] rad, mx_w, my_w, rnd;
	logic signed [63:0] bx0_s8, bx1_s8, by0_s8, by1_s8;
	logic [CONIC_N-1:0][31:0] conic_s8;

	assign rad = {{(64 - RAD_W){1'b0}}, prod_s7[PR_W-1:FRAC_BITS]};
	assign mx_w = {{32{mx_s7[31]}}, mx_s7};
	assign my_w = {{32{my_s7[31]}}, my_s7};
	assign rnd = {{(64 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			bx0_s8 <= (mx_w - rad) >>> FRAC_BITS;
			bx1_s8 <= (mx_w + rad + rnd) >>> FRAC_BITS;
			by0_s8 <= (my_w - rad) >>> FRAC_BITS;
			by1_s8 <= (my_w + rad + rnd) >>> FRAC_BITS;
			conic_s8 <= conic_s7;
		end
	end

	// Stage 9: cull and output register.
	logic vis;
	logic [CONIC_N-1:0][31:0] conic_s9;
	logic [15:0] bx0_s9, bx1_s9, by0_s9, by1_s9;
	logic vis_s9;

	assign vis = !(bx1_s8 < 64'sd0 || by1_s8 < 64'sd0 ||
		bx0_s8 >= $signed({{(64 - DIM_W){1'b0}}, width_q}) ||
		by0_s8 >= $signed({{(64 - DIM_W){1'b0}}, height_q}));

	always_ff @(posedge clk) begin
		if (adv) begin
			conic_s9 <= conic_s8;
			vis_s9 <= vis;
			bx0_s9 <= vis ? clamp16(bx0_s8) : 16'd1;
			bx1_s9 <= vis ? clamp16(bx1_s8) : 16'd0;
			by0_s9 <= vis ? clamp16(by0_s8) : 16'd1;
			by1_s9 <= vis ? clamp16(by1_s8) : 16'd0;
		end
	end

	// Valid bits of the stages outside the submodules.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= div_valid;
			v_s6 <= sq1_valid;
			v_s7 <= sq2_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign out_valid = v_s9;
	assign conic_xx = conic_s9[0];
	assign conic_xy = conic_s9[1];
	assign conic_yx = conic_s9[2];
	assign conic_yy = conic_s9[3];
	assign box_min_x = bx0_s9;
	assign box_max_x = bx1_s9;
	assign box_min_y = by0_s9;
	assign box_max_y = by1_s9;
	assign visible = vis_s9;

	logic empty_box, ordered_box;

	assign empty_box = box_min_x == 16'sd1 && box_max_x == 16'sd0 &&
		box_min_y == 16'sd1 && box_max_y == 16'sd0;
	assign ordered_box = box_min_x <= box_max_x && box_min_y <= box_max_y;

	`GCB_ASSERT_IMPL(a_cull_box, out_valid && !visible, empty_box)
	`GCB_ASSERT_IMPL(a_box_order, out_valid && visible, ordered_box)
	`GCB_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(v_s5) && $stable(v_s6) && $stable(v_s1))

endmodule
